FILE: rtl/pbrs_pkg.sv
// ----------------------------------------------------------------------------
// pbrs_pkg
// Shared types and constants of the phase-binned random stimulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrs_pkg;

    localparam int NUM_BINS_DEF    = 10;
    localparam int TRAIN_EDGES_DEF = 10;
    localparam int TIME_WIDTH_DEF  = 24;

    localparam int BIN_W  = 4;
    localparam int RND_W  = 16;
    localparam int PULSE_W = 16;
    localparam int GOAL_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [BIN_W-1:0]   NO_BIN          = 4'hF;
    localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 16'd100;
    localparam logic [GOAL_W-1:0]  ROT_GOAL_RST    = 8'd20;

    localparam logic REG_PULSE_TICKS    = 1'b0;
    localparam logic REG_ROTATIONS_GOAL = 1'b1;

    typedef struct packed {
        logic             sensor_level;
        logic [RND_W-1:0] random_value;
    } t_in_item;

    typedef struct packed {
        logic             stim_pulse;
        logic             done_light;
        logic             is_trained;
        logic [BIN_W-1:0] chosen_bin;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_start;
        logic div_load;
        logic rd_last;
        logic swap;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic draw;
        logic train_final;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/phase_binned_random_stimulator.sv
// ----------------------------------------------------------------------------
// phase_binned_random_stimulator
// Learns the trigger period, then fires a pulse in a randomly drawn phase bin.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick and yields exactly one result beat.
// A tick is walked from acceptance through evaluation to the result state,
// where its result is registered and offered, and the next tick is taken only
// once the sequencer is back in idle. An edge that draws a bin first reads
// the bag at the drawn slot and at its tail, one read per cycle, then the
// wait is multiplied out; the edge that ends training waits for the divider,
// where the interval sum is multiplied by the reciprocal of the divisor to
// form the bin size. A new tick is taken while the previous result waits; a
// result that is still not taken then holds the next tick in its last cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_binned_random_stimulator #(
    parameter int NUM_BINS    = pbrs_pkg::NUM_BINS_DEF,
    parameter int TRAIN_EDGES = pbrs_pkg::TRAIN_EDGES_DEF,
    parameter int TIME_WIDTH  = pbrs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire pbrs_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pbrs_pkg::t_out_item                o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pbrs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [pbrs_pkg::APB_DW-1:0]   pwdata,
    output logic      [pbrs_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    logic [pbrs_pkg::PULSE_W-1:0] r_pulse_ticks;
    logic [pbrs_pkg::GOAL_W-1:0]  r_rot_goal;
    logic                         w_wr;
    pbrs_pkg::t_cmd               w_cmd;
    pbrs_pkg::t_sts               w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= pbrs_pkg::PULSE_TICKS_RST;
            r_rot_goal    <= pbrs_pkg::ROT_GOAL_RST;
        end else if (w_wr) begin
            if (paddr[2] == pbrs_pkg::REG_ROTATIONS_GOAL) begin
                r_rot_goal <= pwdata[pbrs_pkg::GOAL_W-1:0];
            end else begin
                r_pulse_ticks <= pwdata[pbrs_pkg::PULSE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == pbrs_pkg::REG_ROTATIONS_GOAL) begin
            prdata = pbrs_pkg::APB_DW'(r_rot_goal);
        end else begin
            prdata = pbrs_pkg::APB_DW'(r_pulse_ticks);
        end
    end

    pbrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pbrs_datapath #(
        .NUM_BINS    (NUM_BINS),
        .TRAIN_EDGES (TRAIN_EDGES),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_data     (i_in_data),
        .i_pulse_ticks (r_pulse_ticks),
        .i_rot_goal    (r_rot_goal),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/pbrs_divider.sv
// ----------------------------------------------------------------------------
// pbrs_divider
// Division by a constant through multiplication with its rounded-up reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrs_divider #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR    = 90
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    output logic      [DIVIDEND_W-1:0] o_quotient,
    output logic                       o_done
);

    localparam int LOG_D   = $clog2(DIVISOR);
    localparam int SHIFT   = DIVIDEND_W + LOG_D;
    localparam int RECIP_W = DIVIDEND_W + 1;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;

    localparam logic [SHIFT:0] POW2 = (SHIFT+1)'(1) << SHIFT;
    localparam logic [SHIFT:0] RECIP_FULL =
        (POW2 + (SHIFT+1)'(DIVISOR - 1)) / (SHIFT+1)'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0] r_prod;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_dividend) * PROD_W'(RECIP);
        end
    end

    assign o_quotient = DIVIDEND_W'(r_prod[PROD_W-1:SHIFT]);
    assign o_done     = r_done;

endmodule

`default_nettype wire

FILE: rtl/pbrs_datapath.sv
// ----------------------------------------------------------------------------
// pbrs_datapath
// Training timer, bin bag, wait and pulse counters, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrs_datapath #(
    parameter int NUM_BINS    = pbrs_pkg::NUM_BINS_DEF,
    parameter int TRAIN_EDGES = pbrs_pkg::TRAIN_EDGES_DEF,
    parameter int TIME_WIDTH  = pbrs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire pbrs_pkg::t_cmd                   i_cmd,
    output pbrs_pkg::t_sts                        o_sts,
    input  wire pbrs_pkg::t_in_item               i_in_data,
    input  wire logic [pbrs_pkg::PULSE_W-1:0]     i_pulse_ticks,
    input  wire logic [pbrs_pkg::GOAL_W-1:0]      i_rot_goal,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output pbrs_pkg::t_out_item                   o_out_data
);

    localparam int BIN_W   = pbrs_pkg::BIN_W;
    localparam int RND_W   = pbrs_pkg::RND_W;
    localparam int GOAL_W  = pbrs_pkg::GOAL_W;
    localparam int CNT_W   = $clog2(NUM_BINS + 1);
    localparam int IDX_W   = $clog2(NUM_BINS);
    localparam int TCNT_W  = $clog2(TRAIN_EDGES);
    localparam int SUM_W   = TIME_WIDTH + TCNT_W;
    localparam int WAIT_W  = TIME_WIDTH + BIN_W;
    localparam int PROD_W  = RND_W + CNT_W;
    localparam int DIVISOR = (TRAIN_EDGES - 1) * NUM_BINS;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_PULSE
    } t_phase;

    pbrs_pkg::t_in_item  r_item;
    pbrs_pkg::t_out_item r_out_data;
    logic                r_out_vld;

    logic                  r_prior;
    logic                  r_seen_first;
    logic [TCNT_W-1:0]     r_icount;
    logic [SUM_W-1:0]      r_sum;
    logic [TIME_WIDTH-1:0] r_ticks;
    logic                  r_trained;
    logic [TIME_WIDTH-1:0] r_bin_size;
    logic [CNT_W-1:0]      r_remain;
    logic [IDX_W-1:0]      r_zpos;
    logic                  r_zvld;
    logic [BIN_W-1:0]      r_last_bin;
    logic [WAIT_W-1:0]     r_wait;
    t_phase                r_phase;
    logic [GOAL_W-1:0]     r_rot;
    logic                  r_done;
    logic                  r_stim;
    logic [IDX_W-1:0]      r_idx;
    logic [BIN_W-1:0]      r_sel;

    logic [BIN_W-1:0]      r_bag [NUM_BINS];
    logic [NUM_BINS-1:0]   r_bag_vld;
    logic [BIN_W-1:0]      r_rd_data;

    logic                  w_edge;
    logic [TIME_WIDTH-1:0] w_tick_inc;
    logic                  w_excl;
    logic [CNT_W-1:0]      w_cand;
    logic [PROD_W-1:0]     w_prod;
    logic [CNT_W-1:0]      w_pick;
    logic [CNT_W-1:0]      w_pick_adj;
    logic [CNT_W-1:0]      w_pick_clamp;
    logic [CNT_W-1:0]      w_remain_dec;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_tail;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [WAIT_W-1:0]     w_wc_mid;
    t_phase                w_ph_mid;
    logic [WAIT_W-1:0]     w_wc_next;
    t_phase                w_ph_next;
    logic                  w_stim_next;
    logic [GOAL_W-1:0]     w_rot_inc;
    logic [SUM_W-1:0]      w_quotient;
    logic                  w_div_done;

    assign w_edge     = r_item.sensor_level & ~r_prior;
    assign w_tick_inc = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;

    assign w_excl = (r_last_bin == BIN_W'(NUM_BINS - 1)) && r_zvld
                    && (r_remain > CNT_W'(1));
    assign w_remain_dec = r_remain - CNT_W'(1);
    assign w_cand       = w_excl ? w_remain_dec : r_remain;
    assign w_prod       = PROD_W'(r_item.random_value) * PROD_W'(w_cand);
    assign w_pick       = w_prod[PROD_W-1:RND_W];
    assign w_pick_adj   = (w_excl && (w_pick >= CNT_W'(r_zpos))) ? w_pick + 1'b1 : w_pick;
    assign w_pick_clamp = (w_pick_adj >= r_remain) ? w_remain_dec : w_pick_adj;
    assign w_idx        = w_pick_clamp[IDX_W-1:0];
    assign w_tail       = w_remain_dec[IDX_W-1:0];
    assign w_rd_addr    = i_cmd.rd_last ? w_tail : w_idx;

    assign w_rot_inc = (r_rot == '1) ? r_rot : r_rot + 1'b1;

    always_comb begin
        w_wc_mid    = r_wait;
        w_ph_mid    = r_phase;
        w_wc_next   = r_wait;
        w_ph_next   = r_phase;
        w_stim_next = 1'b0;
        if (r_phase == PH_WAIT && r_wait == '0) begin
            w_wc_mid = WAIT_W'(i_pulse_ticks);
            w_ph_mid = PH_PULSE;
        end
        if (w_ph_mid == PH_PULSE) begin
            w_stim_next = 1'b1;
            if (w_wc_mid <= WAIT_W'(1)) begin
                w_wc_next = '0;
                w_ph_next = PH_IDLE;
            end else begin
                w_wc_next = w_wc_mid - 1'b1;
                w_ph_next = PH_PULSE;
            end
        end else if (w_ph_mid == PH_WAIT) begin
            w_wc_next = w_wc_mid - 1'b1;
        end
    end

    pbrs_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (DIVISOR)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .o_quotient (w_quotient),
        .o_done     (w_div_done)
    );

    assign o_sts.draw        = r_trained && (r_phase == PH_IDLE) && w_edge;
    assign o_sts.train_final = !r_trained && w_edge && r_seen_first
                               && (r_icount == TCNT_W'(TRAIN_EDGES - 1));
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_busy    = r_out_vld && !i_out_ready;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_bag_vld[w_rd_addr] ? r_bag[w_rd_addr] : BIN_W'(w_rd_addr);
        if (i_cmd.swap) begin
            r_bag[r_idx] <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.eval) begin
            r_idx <= w_idx;
        end
        if (i_cmd.rd_last) begin
            r_sel <= r_rd_data;
        end
        if (i_cmd.emit) begin
            r_out_data.stim_pulse <= r_stim;
            r_out_data.done_light <= r_done;
            r_out_data.is_trained <= r_trained;
            r_out_data.chosen_bin <= r_last_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_prior      <= 1'b0;
            r_seen_first <= 1'b0;
            r_icount     <= '0;
            r_sum        <= '0;
            r_ticks      <= '0;
            r_trained    <= 1'b0;
            r_bin_size   <= '0;
            r_remain     <= CNT_W'(NUM_BINS);
            r_zpos       <= '0;
            r_zvld       <= 1'b1;
            r_bag_vld    <= '0;
            r_last_bin   <= pbrs_pkg::NO_BIN;
            r_wait       <= '0;
            r_phase      <= PH_IDLE;
            r_rot        <= '0;
            r_done       <= 1'b0;
            r_stim       <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (i_cmd.eval) begin
                r_prior <= r_item.sensor_level;
                if (!r_trained) begin
                    r_stim  <= 1'b0;
                    r_ticks <= w_edge ? '0 : w_tick_inc;
                    if (w_edge) begin
                        if (!r_seen_first) begin
                            r_seen_first <= 1'b1;
                        end else if (r_icount != TCNT_W'(TRAIN_EDGES - 1)) begin
                            r_sum    <= r_sum + SUM_W'(w_tick_inc);
                            r_icount <= r_icount + 1'b1;
                        end else begin
                            r_trained <= 1'b1;
                            r_icount  <= '0;
                        end
                    end
                end else if (r_phase != PH_IDLE) begin
                    r_stim  <= w_stim_next;
                    r_wait  <= w_wc_next;
                    r_phase <= w_ph_next;
                end else begin
                    r_stim  <= 1'b0;
                end
            end

            if (i_cmd.div_load) begin
                r_bin_size <= w_quotient[TIME_WIDTH-1:0];
            end

            if (i_cmd.swap) begin
                r_last_bin <= r_sel;
                if (w_remain_dec == '0) begin
                    r_bag_vld <= '0;
                    r_remain  <= CNT_W'(NUM_BINS);
                    r_zpos    <= '0;
                    r_zvld    <= 1'b1;
                    r_rot     <= w_rot_inc;
                    if (w_rot_inc >= i_rot_goal) begin
                        r_done <= 1'b1;
                    end
                end else begin
                    r_bag_vld[r_idx] <= 1'b1;
                    r_remain         <= w_remain_dec;
                    if (r_zvld) begin
                        if (r_idx == r_zpos) begin
                            r_zvld <= 1'b0;
                        end else if (r_zpos == w_tail) begin
                            r_zpos <= r_idx;
                        end
                    end
                end
            end

            if (i_cmd.mul) begin
                r_wait  <= WAIT_W'(r_sel) * WAIT_W'(r_bin_size);
                r_phase <= PH_WAIT;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/pbrs_ctrl.sv
// ----------------------------------------------------------------------------
// pbrs_ctrl
// Sequencer that walks each tick beat through evaluation, draw or division, and result.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrs_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pbrs_pkg::t_sts i_sts,
    output pbrs_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_RD_LAST,
        S_SWAP,
        S_MUL,
        S_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    priority if (i_sts.draw) begin
                        r_state <= S_RD_LAST;
                    end else if (i_sts.train_final) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_RD_LAST: r_state <= S_SWAP;
                S_SWAP:    r_state <= S_MUL;
                S_MUL:     r_state <= S_EMIT;
                S_EMIT: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.eval      = (r_state == S_EVAL);
    assign o_cmd.div_start = (r_state == S_EVAL) && i_sts.train_final;
    assign o_cmd.div_load  = (r_state == S_DIV) && i_sts.div_done;
    assign o_cmd.rd_last   = (r_state == S_RD_LAST);
    assign o_cmd.swap      = (r_state == S_SWAP);
    assign o_cmd.mul       = (r_state == S_MUL);
    assign o_cmd.emit      = (r_state == S_EMIT) && !i_sts.out_busy;

endmodule

`default_nettype wire

FILE: verif/phase_binned_random_stimulator_tb.sv
// ----------------------------------------------------------------------------
// phase_binned_random_stimulator_tb
// Self-checking testbench of the phase-binned random stimulator.
// ----------------------------------------------------------------------------
// A queue of tick beats is filled phase by phase. The first phase opens with
// a few ticks at the field extremes and a run of clean trigger periods that
// trains the bin size. After that come mostly well-formed periods with random
// words, mixed with short periods whose edges hit a busy block and with
// level noise. A clocked driver offers the ticks and runs a tick-by-tick model
// of the block on every accepted beat. A clocked monitor compares each result
// beat field by field with the oldest predicted one. Both sides idle at
// random, and the receiver holds off once for a long stretch. Before each
// phase the block is drained and both registers are rewritten and read back,
// including zero pulse length, zero rotation goal and the upper extremes.
// ----------------------------------------------------------------------------

module phase_binned_random_stimulator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pbrs_pkg::*;

    localparam int NUM_BINS    = NUM_BINS_DEF;
    localparam int TRAIN_EDGES = TRAIN_EDGES_DEF;
    localparam int TIME_WIDTH  = TIME_WIDTH_DEF;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_PULSE
    } t_tick_phase;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    phase_binned_random_stimulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_in_item  pending_ticks[$];
    t_out_item expected_outputs[$];
    t_out_item oldest_output;

    int ticks_pushed   = 0;
    int ticks_accepted = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int in_gap         = 0;
    int in_quiet       = 0;
    int out_stall      = 0;
    int out_quiet      = 0;

    logic [PULSE_W-1:0]    cfg_pulse;
    logic [GOAL_W-1:0]     cfg_goal;

    logic                  st_prior;
    logic                  st_seen;
    logic [3:0]            st_icount;
    logic [27:0]           st_isum;
    logic [TIME_WIDTH-1:0] st_since;
    logic                  st_trained;
    logic [TIME_WIDTH-1:0] st_bin_size;
    logic [BIN_W-1:0]      st_bag [NUM_BINS];
    logic [4:0]            st_remain;
    logic [BIN_W-1:0]      st_last;
    logic [27:0]           st_wait;
    t_tick_phase           st_phase;
    logic [7:0]            st_rot;
    logic                  st_done;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void refill_bag();
        for (int i = 0; i < NUM_BINS; i++) begin
            st_bag[i] = BIN_W'(i);
        end
        st_remain = 5'(NUM_BINS);
    endfunction

    function automatic t_out_item predict_tick(t_in_item t);
        t_out_item   r;
        logic        rise;
        logic        excl;
        logic [4:0]  n;
        logic [4:0]  cnt;
        logic [4:0]  zpos;
        logic [4:0]  idx;
        logic [31:0] prod;
        logic [3:0]  sel;
        rise = t.sensor_level && !st_prior;
        r = '0;
        if (!st_trained) begin
            if (st_since != TIME_MAX) begin
                st_since++;
            end
            if (rise) begin
                if (!st_seen) begin
                    st_seen = 1'b1;
                end else if (st_icount < TRAIN_EDGES - 1) begin
                    st_isum = st_isum + st_since;
                    st_icount++;
                end else begin
                    st_bin_size = TIME_WIDTH'((st_isum / (TRAIN_EDGES - 1)) / NUM_BINS);
                    st_trained = 1'b1;
                    st_icount = '0;
                end
                st_since = '0;
            end
        end else if (st_phase == PH_IDLE) begin
            if (rise) begin
                n = st_remain;
                if (n == 0 || n > NUM_BINS) begin
                    refill_bag();
                    n = st_remain;
                end
                zpos = n;
                for (int i = NUM_BINS - 1; i >= 0; i--) begin
                    if (i < n && st_bag[i] == '0) begin
                        zpos = 5'(i);
                    end
                end
                excl = (st_last == BIN_W'(NUM_BINS - 1)) && (zpos < n) && (n > 1);
                cnt = excl ? n - 5'd1 : n;
                prod = t.random_value * cnt;
                idx = prod[20:16];
                if (excl && idx >= zpos) begin
                    idx++;
                end
                if (idx >= n) begin
                    idx = n - 5'd1;
                end
                sel = st_bag[idx];
                st_bag[idx] = st_bag[n - 5'd1];
                st_remain = n - 5'd1;
                if (st_remain == 0) begin
                    refill_bag();
                    if (st_rot != 8'd255) begin
                        st_rot++;
                    end
                    if (st_rot >= cfg_goal) begin
                        st_done = 1'b1;
                    end
                end
                st_last = sel;
                st_wait = sel * st_bin_size;
                st_phase = PH_WAIT;
            end
        end else begin
            if (st_phase == PH_WAIT) begin
                if (st_wait == 0) begin
                    st_phase = PH_PULSE;
                    st_wait = 28'(cfg_pulse);
                end else begin
                    st_wait--;
                end
            end
            if (st_phase == PH_PULSE) begin
                r.stim_pulse = 1'b1;
                if (st_wait <= 1) begin
                    st_wait = '0;
                    st_phase = PH_IDLE;
                end else begin
                    st_wait--;
                end
            end
        end
        st_prior = t.sensor_level;
        r.done_light = st_done;
        r.is_trained = st_trained;
        r.chosen_bin = st_last;
        return r;
    endfunction

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = 40;
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [RND_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return RND_W'($urandom);
    endfunction

    task automatic push_tick(input logic level, input logic [RND_W-1:0] word);
        t_in_item t;
        t.sensor_level = level;
        t.random_value = word;
        pending_ticks.push_back(t);
        ticks_pushed++;
    endtask

    task automatic push_wave(input int period, input int high_len);
        for (int i = 0; i < period; i++) begin
            push_tick(i < high_len, rand_word());
        end
    endtask

    task automatic push_random_wave(input int ok_period);
        int r;
        int period;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            period = $urandom_range(ok_period, ok_period + 20);
            push_wave(period, $urandom_range(1, period - 1));
        end else if (r < 88) begin
            period = $urandom_range(2, 8);
            push_wave(period, $urandom_range(1, period - 1));
        end else begin
            repeat ($urandom_range(1, 8)) push_tick(1'($urandom), rand_word());
        end
    endtask

    task automatic wait_drained();
        while (ticks_accepted != ticks_pushed || expected_outputs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] stored;
        stored = (idx == REG_PULSE_TICKS) ? APB_DW'(value[PULSE_W-1:0])
                                          : APB_DW'(value[GOAL_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            $display("%0t ns: register %0d readback expected %0h actual %0h",
                     $time, idx, stored, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PULSE_TICKS) begin
            cfg_pulse = stored[PULSE_W-1:0];
        end else begin
            cfg_goal = stored[GOAL_W-1:0];
        end
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        $display("%0t ns: %s expected %0d actual %0d", $time, field, exp_v, act_v);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            cfg_pulse   = PULSE_TICKS_RST;
            cfg_goal    = ROT_GOAL_RST;
            st_prior    = 1'b0;
            st_seen     = 1'b0;
            st_icount   = '0;
            st_isum     = '0;
            st_since    = '0;
            st_trained  = 1'b0;
            st_bin_size = '0;
            refill_bag();
            st_last     = NO_BIN;
            st_wait     = '0;
            st_phase    = PH_IDLE;
            st_rot      = '0;
            st_done     = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_outputs.push_back(predict_tick(i_in_data));
                void'(pending_ticks.pop_front());
                ticks_accepted++;
                in_gap = pick_gap(in_quiet);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_ticks[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off once, after the 500th result, in the middle of a
    // phase, so that the block fills up and stalls the input side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_outputs.size() == 0) begin
                    $display("%0t ns: result beat expected none actual %p", $time, o_out_data);
                    mismatch_count++;
                end else begin
                    oldest_output = expected_outputs.pop_front();
                    if (o_out_data.stim_pulse !== oldest_output.stim_pulse)
                        report_mismatch("stim_pulse", oldest_output.stim_pulse,
                                        o_out_data.stim_pulse);
                    if (o_out_data.done_light !== oldest_output.done_light)
                        report_mismatch("done_light", oldest_output.done_light,
                                        o_out_data.done_light);
                    if (o_out_data.is_trained !== oldest_output.is_trained)
                        report_mismatch("is_trained", oldest_output.is_trained,
                                        o_out_data.is_trained);
                    if (o_out_data.chosen_bin !== oldest_output.chosen_bin)
                        report_mismatch("chosen_bin", oldest_output.chosen_bin,
                                        o_out_data.chosen_bin);
                end
                results_seen++;
                out_stall = (results_seen == 500) ? 300 : pick_gap(out_quiet);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(REG_PULSE_TICKS, 32'd0);
        write_reg(REG_ROTATIONS_GOAL, 32'd255);
        push_tick(1'b1, 16'hFFFF);
        push_tick(1'b1, 16'h0000);
        push_tick(1'b0, 16'hFFFF);
        push_tick(1'b0, 16'h0000);
        push_tick(1'b1, 16'h8000);
        push_tick(1'b0, 16'h7FFF);
        repeat (12) push_wave($urandom_range(12, 32), 4);
        while (ticks_pushed < 420) push_random_wave(22);
        wait_drained();

        write_reg(REG_PULSE_TICKS, 32'd3);
        write_reg(REG_ROTATIONS_GOAL, 32'd2);
        while (ticks_pushed < 820) push_random_wave(25);
        wait_drained();

        write_reg(REG_PULSE_TICKS, 32'd1);
        write_reg(REG_ROTATIONS_GOAL, 32'd0);
        while (ticks_pushed < 1220) push_random_wave(23);
        wait_drained();

        write_reg(REG_PULSE_TICKS, 32'd65535);
        write_reg(REG_ROTATIONS_GOAL, 32'd1);
        while (ticks_pushed < 1450) push_random_wave(30);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_outputs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: phase_binned_random_stimulator.f
rtl/pbrs_pkg.sv
rtl/pbrs_divider.sv
rtl/pbrs_datapath.sv
rtl/pbrs_ctrl.sv
rtl/phase_binned_random_stimulator.sv
verif/phase_binned_random_stimulator_tb.sv
